### hdl/nls_pkg.sv
// ============================================================================
// nls_pkg: shared types and constants of the nearest lattice site pipeline
// Fixed-point format, derived widths, stage numbering, register indexes and
// the sublattice site table.
// ============================================================================
package nls_pkg;

    localparam int FRAC_BITS = 16;

    localparam int COORD_W = 32;
    localparam int CONST_W = 24;
    localparam int ORG_W   = 24;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 25;
    localparam int DATA_W  = 24;
    localparam int CFG_IDX_W = 3;

    // origin offset o*L and the shifted coordinate
    localparam int PROD_W = ORG_W + CONST_W + 1;
    localparam int OFF_W  = PROD_W - FRAC_BITS;
    localparam int SH_W   = ((OFF_W > COORD_W + 1) ? OFF_W : COORD_W + 1) + 1;
    localparam int DIV1_ST = (SH_W + 1) / 2;
    localparam int Q_W    = SH_W + 1;
    localparam int R_W    = CONST_W + 1;

    // minimum-image gaps in doubled units
    localparam int D_W    = CONST_W + 3;
    localparam int FD_W   = CONST_W + 1;
    localparam int SQ_W   = 2 * CONST_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int SQRT_ST = (ROOT_W + 1) / 2;

    // cell rounding
    localparam int V_W    = Q_W + FRAC_BITS + 3;
    localparam int VR_W   = COORD_W + SCALE_W + 1;
    localparam int K_W    = VR_W - FRAC_BITS;
    localparam int KM_W   = K_W - 1;
    localparam int N_W    = KM_W + FRAC_BITS;
    localparam int Q2_BITS = COORD_W + 1;
    localparam int DIV2_ST = (Q2_BITS + 1) / 2;

    localparam logic signed [63:0] QLIM = 64'sh0000_0010_0000_0000;
    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

    // stage numbering
    localparam int S_IN   = 0;
    localparam int S_SH   = 1;
    localparam int S_D1   = 2;
    localparam int S_QR   = S_D1 + DIV1_ST;
    localparam int S_FOLD = S_QR + 1;
    localparam int S_SQ   = S_FOLD + 1;
    localparam int S_SUM  = S_SQ + 1;
    localparam int S_PAIR = S_SUM + 1;
    localparam int S_BEST = S_PAIR + 1;
    localparam int S_V    = S_BEST + 1;
    localparam int S_SAT  = S_V + 1;
    localparam int S_MUL  = S_SAT + 1;
    localparam int S_K    = S_MUL + 1;
    localparam int S_D2   = S_K + 1;
    localparam int S_OUT  = S_D2 + DIV2_ST;
    localparam int N_STAGE = S_OUT + 1;
    localparam int S_ROOT_END = S_BEST + SQRT_ST;
    localparam int DLY_N  = S_OUT - S_ROOT_END;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LATTICE_CONSTANT = 3'd0,
        CFG_LATTICE_KIND     = 3'd1,
        CFG_ORIGIN_X         = 3'd2,
        CFG_ORIGIN_Y         = 3'd3,
        CFG_ORIGIN_Z         = 3'd4,
        CFG_ROUND_SCALE      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cell_x;
        logic signed [COORD_W-1:0] cell_y;
        logic signed [COORD_W-1:0] cell_z;
        logic [DIST_W-1:0]         site_distance;
        logic signed [COORD_W-1:0] echo_x;
        logic signed [COORD_W-1:0] echo_y;
        logic signed [COORD_W-1:0] echo_z;
    } result_t;

    // half-unit offsets {x,y,z} of a site; kind 0 is bcc, 1 is fcc
    function automatic logic [2:0] site_bits(input logic kind, input logic [1:0] s);
        logic [2:0] b;
        b = 3'b000;
        if (kind == 1'b0) begin
            b = s[0] ? 3'b111 : 3'b000;
        end
        else begin
            case (s)
                2'd0:    b = 3'b000;
                2'd1:    b = 3'b110;
                2'd2:    b = 3'b101;
                2'd3:    b = 3'b011;
                default: b = 3'b000;
            endcase
        end
        return b;
    endfunction

endpackage

### hdl/nearest_lattice_site.sv
// ============================================================================
// nearest_lattice_site: nearest bcc/fcc sublattice site of an atom position
// Streams one position per cycle through a fixed-depth pipeline if unstalled.
// ============================================================================
// Usage:
//   item channel (item_valid/item_ready/item): one atom position per
//   transfer. result channel (result_valid/result_ready/result): the nearest
//   site cell, its minimum-image distance and the echoed position, one per
//   item, in order. cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data):
//   register writes, always ready; write only while the pipeline is empty.
//   The pipeline runs through two radix-4 long dividers (coordinate by
//   lattice constant, cell by round scale) and the compare and rounding
//   stages between them.
//   Throughput: one item per cycle while the receiver does not stall.
//   Reset clears all valid bits and loads the register defaults.
//   A stalled receiver holds the whole pipeline: the last stage keeps its
//   result and item_ready drops until the result is taken; bubbles inside
//   the pipeline move forward whenever the output stage is free.
// ============================================================================
module nearest_lattice_site
    import nls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------ config
    logic [CONST_W-1:0]      lconst_reg;
    logic                    kind_reg;
    logic signed [ORG_W-1:0] org_reg [3];
    logic [SCALE_W-1:0]      rscale_reg;
    logic [CONST_W-1:0]      l_eff;
    logic [SCALE_W-1:0]      r_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lconst_reg <= CONST_W'(187432);
            kind_reg   <= 1'b0;
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            rscale_reg <= SCALE_W'(100);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LATTICE_CONSTANT: lconst_reg <= cfg_data[CONST_W-1:0];
                CFG_LATTICE_KIND:     kind_reg   <= cfg_data[0];
                CFG_ORIGIN_X:         org_reg[0] <= cfg_data[ORG_W-1:0];
                CFG_ORIGIN_Y:         org_reg[1] <= cfg_data[ORG_W-1:0];
                CFG_ORIGIN_Z:         org_reg[2] <= cfg_data[ORG_W-1:0];
                CFG_ROUND_SCALE:      rscale_reg <= cfg_data[SCALE_W-1:0];
                default:              ;
            endcase
        end
    end

    assign l_eff = (lconst_reg == '0) ? CONST_W'(1) : lconst_reg;
    assign r_eff = (rscale_reg == '0) ? SCALE_W'(1) : rscale_reg;

    // origin offset floor(o*L / 2^F), refreshed every cycle from the registers
    logic signed [OFF_W-1:0] off_reg [3];

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            off_reg[a] <= OFF_W'((PROD_W'(org_reg[a]) *
                                   $signed({1'b0, l_eff})) >>> FRAC_BITS);
        end
    end

    // --------------------------------------------------------------- control
    logic [N_STAGE-1:0] vld_reg;
    logic               adv;
    item_t              echo_reg [N_STAGE];

    assign adv          = !vld_reg[S_OUT] || result_ready;
    assign item_ready   = adv;
    assign result_valid = vld_reg[S_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N_STAGE-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            echo_reg[0] <= item;
            for (int k = 1; k < N_STAGE; k++)
            begin
                echo_reg[k] <= echo_reg[k-1];
            end
        end
    end

    // ------------------------------------------------- shift and sign split
    logic signed [COORD_W-1:0] coord [3];
    logic [SH_W-1:0]           sh_mag_reg [3];
    logic                      sh_neg_reg [3];

    assign coord[0] = echo_reg[S_IN].coord_x;
    assign coord[1] = echo_reg[S_IN].coord_y;
    assign coord[2] = echo_reg[S_IN].coord_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic signed [SH_W-1:0] sh;
                sh = SH_W'(coord[a]) - SH_W'(off_reg[a]);
                sh_neg_reg[a] <= sh[SH_W-1];
                sh_mag_reg[a] <= sh[SH_W-1] ? SH_W'(-sh) : SH_W'(sh);
            end
        end
    end

    // ------------------------------- divider: |shift| by L, two bits a stage
    logic [CONST_W-1:0] d1_rem_reg [DIV1_ST][3];
    logic [SH_W-1:0]    d1_dq_reg  [DIV1_ST][3];
    logic               d1_neg_reg [DIV1_ST][3];

    for (genvar g = 0; g < DIV1_ST; g++)
    begin : g_div1
        logic [CONST_W-1:0] rem_in [3];
        logic [SH_W-1:0]    dq_in  [3];
        logic               neg_in [3];

        if (g == 0)
        begin : g_src0
            always_comb
            begin
                for (int a = 0; a < 3; a++)
                begin
                    rem_in[a] = '0;
                    dq_in[a]  = sh_mag_reg[a];
                    neg_in[a] = sh_neg_reg[a];
                end
            end
        end
        else
        begin : g_srcn
            always_comb
            begin
                for (int a = 0; a < 3; a++)
                begin
                    rem_in[a] = d1_rem_reg[g-1][a];
                    dq_in[a]  = d1_dq_reg[g-1][a];
                    neg_in[a] = d1_neg_reg[g-1][a];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    logic [CONST_W-1:0] rem;
                    logic [SH_W-1:0]    dq;
                    logic [CONST_W:0]   t;
                    logic               ge;
                    rem = rem_in[a];
                    dq  = dq_in[a];
                    for (int j = 0; j < 2; j++)
                    begin
                        if (g * 2 + j < SH_W)
                        begin
                            t   = {rem, dq[SH_W-1]};
                            ge  = (t >= {1'b0, l_eff});
                            rem = ge ? CONST_W'(t - {1'b0, l_eff}) : CONST_W'(t);
                            dq  = {dq[SH_W-2:0], ge};
                        end
                    end
                    d1_rem_reg[g][a] <= rem;
                    d1_dq_reg[g][a]  <= dq;
                    d1_neg_reg[g][a] <= neg_in[a];
                end
            end
        end
    end

    // ------------------------------------------- signed quotient, remainder
    logic signed [Q_W-1:0] q_reg [3];
    logic signed [R_W-1:0] r_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic signed [Q_W-1:0] qm;
                logic signed [R_W-1:0] rm;
                qm = $signed({1'b0, d1_dq_reg[DIV1_ST-1][a]});
                rm = $signed({1'b0, d1_rem_reg[DIV1_ST-1][a]});
                q_reg[a] <= d1_neg_reg[DIV1_ST-1][a] ? -qm : qm;
                r_reg[a] <= d1_neg_reg[DIV1_ST-1][a] ? -rm : rm;
            end
        end
    end

    // --------------------------- fold gaps for site offset 0 and 1/2 per axis
    logic signed [FD_W-1:0] fd_reg  [3][2];
    logic signed [Q_W-1:0]  qc_reg  [S_FOLD:S_BEST][3];
    logic signed [1:0]      mir_reg [S_FOLD:S_BEST][3][2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic signed [D_W-1:0] r2;
                logic signed [D_W-1:0] d;
                logic signed [D_W-1:0] ad;
                logic signed [D_W-1:0] lw;
                logic signed [63:0]    qw;
                lw = D_W'($signed({1'b0, l_eff}));
                r2 = D_W'(r_reg[a]) <<< 1;
                for (int b = 0; b < 2; b++)
                begin
                    d  = (b == 1) ? (lw - r2) : -r2;
                    ad = (d < 0) ? -d : d;
                    if (ad > lw)
                    begin
                        fd_reg[a][b]          <= FD_W'((lw <<< 1) - ad);
                        mir_reg[S_FOLD][a][b] <= (r_reg[a] < 0) ? -2'sd1 : 2'sd1;
                    end
                    else
                    begin
                        fd_reg[a][b]          <= FD_W'(ad);
                        mir_reg[S_FOLD][a][b] <= 2'sd0;
                    end
                end
                // clamp the quotient to +-2^36
                qw = 64'(q_reg[a]);
                if (qw > QLIM)
                begin
                    qc_reg[S_FOLD][a] <= Q_W'(QLIM);
                end
                else if (qw < -QLIM)
                begin
                    qc_reg[S_FOLD][a] <= Q_W'(-QLIM);
                end
                else
                begin
                    qc_reg[S_FOLD][a] <= q_reg[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = S_FOLD + 1; k <= S_BEST; k++)
            begin
                qc_reg[k]  <= qc_reg[k-1];
                mir_reg[k] <= mir_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------ squares and sums
    logic [SQ_W-1:0]  sq_reg  [3][2];
    logic [SUM_W-1:0] sum_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 2; b++)
                begin
                    logic signed [2*FD_W-1:0] p;
                    p = fd_reg[a][b] * fd_reg[a][b];
                    sq_reg[a][b] <= p[SQ_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < 4; s++)
            begin
                logic [2:0] sb;
                sb = site_bits(kind_reg, 2'(s));
                sum_reg[s] <= SUM_W'(sq_reg[0][sb[2]]) + SUM_W'(sq_reg[1][sb[1]])
                            + SUM_W'(sq_reg[2][sb[0]]);
            end
        end
    end

    // ----------------------------------------- pick the first nearest site
    logic [SUM_W-1:0] p_sum_reg [2];
    logic [1:0]       p_idx_reg [2];
    logic [SUM_W-1:0] best_sum_reg;
    logic [1:0]       best_idx_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int h = 0; h < 2; h++)
            begin
                logic w;
                w = (sum_reg[2*h+1] < sum_reg[2*h]);
                p_sum_reg[h] <= w ? sum_reg[2*h+1] : sum_reg[2*h];
                p_idx_reg[h] <= {1'(h), w};
            end
            if (kind_reg && (p_sum_reg[1] < p_sum_reg[0]))
            begin
                best_sum_reg <= p_sum_reg[1];
                best_idx_reg <= p_idx_reg[1];
            end
            else
            begin
                best_sum_reg <= p_sum_reg[0];
                best_idx_reg <= p_idx_reg[0];
            end
        end
    end

    // -------------------------------------------- cell position and rounding
    logic signed [V_W-1:0]      v_reg   [3];
    logic signed [COORD_W-1:0]  v32_reg [3];
    logic signed [VR_W-1:0]     vr_reg  [3];
    logic [KM_W-1:0]            km_reg  [3];
    logic                       kn_reg  [3];
    logic [2:0]                 best_bits;

    assign best_bits = site_bits(kind_reg, best_idx_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic                  b;
                logic signed [V_W-1:0] half;
                logic signed [63:0]    vw;
                logic signed [K_W-1:0] kk;
                b    = best_bits[2-a];
                half = b ? (V_W'(1) <<< (FRAC_BITS - 1)) : '0;
                v_reg[a] <= ((V_W'(qc_reg[S_BEST][a]) + V_W'(mir_reg[S_BEST][a][b]))
                             <<< FRAC_BITS) + half + V_W'(org_reg[a]);
                vw = 64'(v_reg[a]);
                if (vw > SAT_HI)
                begin
                    v32_reg[a] <= COORD_W'(SAT_HI);
                end
                else if (vw < SAT_LO)
                begin
                    v32_reg[a] <= COORD_W'(SAT_LO);
                end
                else
                begin
                    v32_reg[a] <= COORD_W'(v_reg[a]);
                end
                vr_reg[a] <= VR_W'(v32_reg[a]) * VR_W'($signed({1'b0, r_eff}));
                kk = K_W'(vr_reg[a] >>> FRAC_BITS);
                kn_reg[a] <= kk[K_W-1];
                km_reg[a] <= kk[K_W-1] ? KM_W'(-kk) : KM_W'(kk);
            end
        end
    end

    // --------------------- divider: k * 2^F by round scale, two bits a stage
    logic [SCALE_W-1:0]  d2_rem_reg [DIV2_ST][3];
    logic [Q2_BITS-1:0]  d2_dq_reg  [DIV2_ST][3];
    logic                d2_neg_reg [DIV2_ST][3];

    for (genvar g = 0; g < DIV2_ST; g++)
    begin : g_div2
        logic [SCALE_W-1:0] rem_in [3];
        logic [Q2_BITS-1:0] dq_in  [3];
        logic               neg_in [3];

        if (g == 0)
        begin : g_src0
            always_comb
            begin
                for (int a = 0; a < 3; a++)
                begin
                    logic [N_W-1:0] n;
                    n = {km_reg[a], {FRAC_BITS{1'b0}}};
                    rem_in[a] = SCALE_W'(n[N_W-1:Q2_BITS]);
                    dq_in[a]  = n[Q2_BITS-1:0];
                    neg_in[a] = kn_reg[a];
                end
            end
        end
        else
        begin : g_srcn
            always_comb
            begin
                for (int a = 0; a < 3; a++)
                begin
                    rem_in[a] = d2_rem_reg[g-1][a];
                    dq_in[a]  = d2_dq_reg[g-1][a];
                    neg_in[a] = d2_neg_reg[g-1][a];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    logic [SCALE_W-1:0] rem;
                    logic [Q2_BITS-1:0] dq;
                    logic [SCALE_W:0]   t;
                    logic               ge;
                    rem = rem_in[a];
                    dq  = dq_in[a];
                    for (int j = 0; j < 2; j++)
                    begin
                        if (g * 2 + j < Q2_BITS)
                        begin
                            t   = {rem, dq[Q2_BITS-1]};
                            ge  = (t >= {1'b0, r_eff});
                            rem = ge ? SCALE_W'(t - {1'b0, r_eff}) : SCALE_W'(t);
                            dq  = {dq[Q2_BITS-2:0], ge};
                        end
                    end
                    d2_rem_reg[g][a] <= rem;
                    d2_dq_reg[g][a]  <= dq;
                    d2_neg_reg[g][a] <= neg_in[a];
                end
            end
        end
    end

    // ---------------------------- integer square root, two bits a stage
    logic [ROOT_W+1:0]  rt_rem_reg  [SQRT_ST];
    logic [ROOT_W-1:0]  rt_root_reg [SQRT_ST];
    logic [SUM_W-1:0]   rt_x_reg    [SQRT_ST];

    for (genvar g = 0; g < SQRT_ST; g++)
    begin : g_sqrt
        logic [ROOT_W+1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  x_in;

        if (g == 0)
        begin : g_src0
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = best_sum_reg;
        end
        else
        begin : g_srcn
            assign rem_in  = rt_rem_reg[g-1];
            assign root_in = rt_root_reg[g-1];
            assign x_in    = rt_x_reg[g-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                logic [ROOT_W+1:0] rem;
                logic [ROOT_W-1:0] root;
                logic [SUM_W-1:0]  x;
                logic [ROOT_W+3:0] t;
                logic [ROOT_W+3:0] trial;
                logic              ge;
                rem  = rem_in;
                root = root_in;
                x    = x_in;
                for (int j = 0; j < 2; j++)
                begin
                    if (g * 2 + j < ROOT_W)
                    begin
                        t     = {rem, x[SUM_W-1 -: 2]};
                        trial = (ROOT_W+4)'({root, 2'b01});
                        ge    = (t >= trial);
                        rem   = ge ? (ROOT_W+2)'(t - trial) : (ROOT_W+2)'(t);
                        root  = {root[ROOT_W-2:0], ge};
                        x     = x << 2;
                    end
                end
                rt_rem_reg[g]  <= rem;
                rt_root_reg[g] <= root;
                rt_x_reg[g]    <= x;
            end
        end
    end

    // hold the distance until the cell path catches up
    logic [DIST_W-1:0] dist_reg [DLY_N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg[0] <= DIST_W'(rt_root_reg[SQRT_ST-1] >> 1);
            for (int k = 1; k < DLY_N; k++)
            begin
                dist_reg[k] <= dist_reg[k-1];
            end
        end
    end

    // -------------------------------------------------------- output stage
    logic signed [COORD_W-1:0] cell_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic signed [Q2_BITS:0] qm;
                qm = $signed({1'b0, d2_dq_reg[DIV2_ST-1][a]});
                if (d2_neg_reg[DIV2_ST-1][a])
                begin
                    // floor for a negative dividend: round the magnitude up
                    qm = -(qm + (Q2_BITS+1)'(d2_rem_reg[DIV2_ST-1][a] != '0));
                end
                // the rounding step can fall one below the signed range
                if (64'(qm) < SAT_LO)
                begin
                    cell_reg[a] <= COORD_W'(SAT_LO);
                end
                else
                begin
                    cell_reg[a] <= COORD_W'(qm);
                end
            end
        end
    end

    always_comb
    begin
        result.cell_x        = cell_reg[0];
        result.cell_y        = cell_reg[1];
        result.cell_z        = cell_reg[2];
        result.site_distance = dist_reg[DLY_N-1];
        result.echo_x        = echo_reg[S_OUT].coord_x;
        result.echo_y        = echo_reg[S_OUT].coord_y;
        result.echo_z        = echo_reg[S_OUT].coord_z;
    end

    // ------------------------------------------------------------ assertions
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_bcc_two_sites: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[S_BEST] && !kind_reg) |-> (best_idx_reg[1] == 1'b0))
        else $error("bcc picked a site beyond the second");

    a_div1_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_QR-1] |-> ((d1_rem_reg[DIV1_ST-1][0] < l_eff)
                          && (d1_rem_reg[DIV1_ST-1][1] < l_eff)
                          && (d1_rem_reg[DIV1_ST-1][2] < l_eff)))
        else $error("coordinate divider remainder not below lattice constant");

    a_div2_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_OUT-1] |-> ((d2_rem_reg[DIV2_ST-1][0] < r_eff)
                           && (d2_rem_reg[DIV2_ST-1][1] < r_eff)
                           && (d2_rem_reg[DIV2_ST-1][2] < r_eff)))
        else $error("cell divider remainder not below round scale");

endmodule
